// ===== src/ira_pkg.sv =====
// Shared constants and codes for the indexed insert/remove store.
package ira_pkg;

   localparam int ENTRY_WIDTH = 32;
   localparam int DEPTH       = 64;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int COUNT_W     = $clog2(DEPTH + 1);
   localparam int POS_W       = 7;
   localparam int VALUE_W     = 32;

   // request modes
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_READ   = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;

   // response status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

// ===== src/ira_req_if.sv =====
// Request channel: mode, position and item for the insert/remove store.
interface ira_req_if import ira_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [POS_W-1:0]   position;
   logic [VALUE_W-1:0] item_value;
   logic               item_given;

   modport source (output valid, mode, position, item_value, item_given, input ready);
   modport sink   (input valid, mode, position, item_value, item_given, output ready);
endinterface

// ===== src/ira_rsp_if.sv =====
// Response channel: status, entry value and entry total of the store.
interface ira_rsp_if import ira_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [VALUE_W-1:0]  entry_value;
   logic [POS_W-1:0]    entry_total;

   modport source (output valid, status, entry_value, entry_total, input ready);
   modport sink   (input valid, status, entry_value, entry_total, output ready);
endinterface

// ===== src/ira_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ira_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/indexed_insert_remove_array.sv =====
// Indexed insert/remove store: one RAM, entries shifted one per cycle.
// Read: fetch, then reply; errors reply at once. Insert: unless appending, shift the
// entries at and above the position up and drain; then put the item and reply. Remove:
// unless last, shift the entries above down and drain; then reply. The next request is
// taken in the cycle after the result is registered; a full output register holds the
// reply back until it drains. Reset clears state, count, pending write and valid.
module indexed_insert_remove_array import ira_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ira_req_if.sink     req_ch,
   ira_rsp_if.source   rsp_ch
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_DRAIN,
      S_PUT,
      S_FETCH,
      S_REPLY
   } state_type;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   idx_ff, idx_in;
   logic [COUNT_W-1:0]   end_ff, end_in;
   logic                 up_ff, up_in;
   logic                 ins_ff, ins_in;
   logic [ADDR_W-1:0]    pos_ff, pos_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [1:0]           status_ff, status_in;
   logic                 wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]    wr_addr_ff, wr_addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]     rsp_total_ff, rsp_total_in;

   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [ENTRY_WIDTH-1:0] ram_wr_data;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [ENTRY_WIDTH-1:0] ram_rd_data;

   logic                 req_take;
   logic                 rsp_free;
   logic [POS_W-1:0]     req_count;
   logic [POS_W-1:0]     req_pos_p1;

   assign req_take   = req_ch.valid && req_ch.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign req_count  = POS_W'(count_ff);
   assign req_pos_p1 = req_ch.position + POS_W'(1);

   // entry store
   ira_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // write port: pending shift write, else the new item
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_addr_ff;
      ram_wr_data = ram_rd_data;
      if (wr_pend_ff) begin
         ram_wr_en = 1'b1;
      end else if (state_ff == S_PUT) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = pos_ff;
         ram_wr_data = ENTRY_WIDTH'(value_ff);
      end
   end

   // read port: request position when idle, else the shift source
   assign ram_rd_addr = (state_ff == S_IDLE) ? req_ch.position[ADDR_W-1:0]
                                             : idx_ff[ADDR_W-1:0];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      up_in         = up_ff;
      ins_in        = ins_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      wr_pend_in    = 1'b0;
      wr_addr_in    = wr_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_total_in  = rsp_total_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               pos_in    = req_ch.position[ADDR_W-1:0];
               value_in  = '0;
               status_in = ST_DONE;
               ins_in    = 1'b0;
               state_in  = S_REPLY;
               unique case (req_ch.mode)
                  MODE_INSERT: begin
                     if (req_ch.position > req_count) begin
                        status_in = ST_RANGE;
                     end else if (count_ff >= COUNT_W'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        // move entries at and above the position up by one
                        ins_in   = 1'b1;
                        value_in = req_ch.item_given ? req_ch.item_value : '0;
                        count_in = count_ff + COUNT_W'(1);
                        up_in    = 1'b1;
                        idx_in   = count_ff - COUNT_W'(1);
                        end_in   = COUNT_W'(req_ch.position);
                        state_in = (req_ch.position == req_count) ? S_PUT : S_SHIFT;
                     end
                  end
                  MODE_READ: begin
                     if (req_ch.position >= req_count) begin
                        status_in = ST_RANGE;
                     end else begin
                        state_in = S_FETCH;
                     end
                  end
                  MODE_REMOVE: begin
                     if (req_ch.position >= req_count) begin
                        status_in = ST_RANGE;
                     end else begin
                        // move entries above the position down by one
                        count_in = count_ff - COUNT_W'(1);
                        up_in    = 1'b0;
                        idx_in   = COUNT_W'(req_pos_p1);
                        end_in   = count_ff - COUNT_W'(1);
                        if (req_pos_p1 < req_count) begin
                           state_in = S_SHIFT;
                        end
                     end
                  end
                  default: begin
                     status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_SHIFT: begin
            // read the source now, write it to its neighbour next cycle
            wr_pend_in = 1'b1;
            wr_addr_in = up_ff ? ADDR_W'(idx_ff + COUNT_W'(1))
                               : ADDR_W'(idx_ff - COUNT_W'(1));
            if (idx_ff == end_ff) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = up_ff ? idx_ff - COUNT_W'(1) : idx_ff + COUNT_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = ins_ff ? S_PUT : S_REPLY;
         end
         S_PUT: begin
            state_in = S_REPLY;
         end
         S_FETCH: begin
            value_in = VALUE_W'(ram_rd_data);
            state_in = S_REPLY;
         end
         S_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = value_ff;
               rsp_total_in  = POS_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      end_ff        <= end_in;
      up_ff         <= up_in;
      ins_ff        <= ins_in;
      pos_ff        <= pos_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      wr_addr_ff    <= wr_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.entry_value = rsp_value_ff;
   assign rsp_ch.entry_total = rsp_total_ff;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the indexed insert/remove store.
`timescale 1ns / 1ps

module tb_top;
   import ira_pkg::*;

   // mode code the block does not define; it must answer with a range error
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1550;
   localparam int TAIL_ITEMS   = 120;
   localparam int SETTLE_CYCLES = 100;

   typedef struct {
      logic [1:0]         mode;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] item_value;
      logic               item_given;
      int                 gap_before;
      bit                 wait_drain;
   } store_req_type;

   typedef struct {
      logic [1:0]         status;
      logic [VALUE_W-1:0] entry_value;
      logic [POS_W-1:0]   entry_total;
   } store_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ira_req_if req_bus ();
   ira_rsp_if rsp_bus ();

   indexed_insert_remove_array uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // mirror of the store contents and its live count
   logic [ENTRY_WIDTH-1:0] mirror_entries [DEPTH];
   int                     mirror_count = 0;

   store_req_type pending_q [$];
   store_rsp_type expected_q [$];
   int            error_count = 0;
   bit            tail_quiet  = 1'b0;

   // driver state
   store_req_type cur_item;
   bit            have_item = 1'b0;
   int            gap_left  = 0;

   // monitor state
   int stall_left = 0;
   int stall_odds = 8;

   // stimulus generator's view of the count
   int gen_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report(input string what);
      error_count++;
      $display("ERROR at %0t: %s", $time, what);
   endtask

   // apply one request to the mirror and return the response it must give
   function automatic store_rsp_type apply_request(input store_req_type r);
      store_rsp_type          rsp;
      logic [ENTRY_WIDTH-1:0] v;
      int                     pos;
      pos = r.position;
      rsp.status      = ST_RANGE;
      rsp.entry_value = '0;
      case (r.mode)
         MODE_INSERT: begin
            if (pos > mirror_count) begin
               rsp.status = ST_RANGE;
            end else if (mirror_count >= DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               v = r.item_given ? r.item_value[ENTRY_WIDTH-1:0] : '0;
               for (int i = mirror_count; i > pos; i--)
                  mirror_entries[i] = mirror_entries[i-1];
               mirror_entries[pos] = v;
               mirror_count++;
               rsp.status      = ST_DONE;
               rsp.entry_value = VALUE_W'(v);
            end
         end
         MODE_READ: begin
            if (pos < mirror_count) begin
               rsp.status      = ST_DONE;
               rsp.entry_value = VALUE_W'(mirror_entries[pos]);
            end
         end
         MODE_REMOVE: begin
            if (pos < mirror_count) begin
               for (int i = pos; i + 1 < mirror_count; i++)
                  mirror_entries[i] = mirror_entries[i+1];
               mirror_count--;
               rsp.status = ST_DONE;
            end
         end
         default: rsp.status = ST_RANGE;
      endcase
      rsp.entry_total = POS_W'(mirror_count);
      return rsp;
   endfunction

   // queue one request and track the count it leaves behind
   task automatic add_item(input logic [1:0] mode, input int pos, input logic [VALUE_W-1:0] val,
                           input logic given, input int gap, input bit drain);
      store_req_type r;
      r.mode       = mode;
      r.position   = POS_W'(pos);
      r.item_value = val;
      r.item_given = given;
      r.gap_before = gap;
      r.wait_drain = drain;
      pending_q.push_back(r);
      if (mode == MODE_INSERT && pos <= gen_count && gen_count < DEPTH)
         gen_count++;
      else if (mode == MODE_REMOVE && pos < gen_count)
         gen_count--;
   endtask

   // pick a position: mostly legal, some on the edge, some anywhere
   function automatic int pick_position(input logic [1:0] mode);
      int roll;
      int top;
      roll = $urandom_range(0, 9);
      top  = (mode == MODE_INSERT) ? gen_count : gen_count - 1;
      if (roll == 0)
         return $urandom_range(0, (1 << POS_W) - 1);
      if (roll == 1 || top < 0)
         return (mode == MODE_INSERT) ? gen_count + 1 : gen_count;
      if (roll == 2)
         return top;
      return $urandom_range(0, top);
   endfunction

   task automatic build_random();
      bit         growing;
      int         roll;
      int         gap;
      int         calm_left;
      bit         drain;
      logic [1:0] mode;
      growing   = 1'b1;
      calm_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // swap direction at the ends so the count sweeps the whole range
         if (growing && gen_count == DEPTH) begin
            add_item(MODE_INSERT, $urandom_range(0, DEPTH), $urandom, 1'b1, 0, 1'b0);
            add_item(MODE_INSERT, $urandom_range(DEPTH + 1, (1 << POS_W) - 1),
                     $urandom, $urandom_range(0, 1), 0, 1'b0);
            growing = 1'b0;
         end else if (!growing && gen_count == 0) begin
            growing = 1'b1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 3)
            mode = MODE_UNUSED;
         else if (roll < 23)
            mode = MODE_READ;
         else if (growing)
            mode = (roll < 83) ? MODE_INSERT : MODE_REMOVE;
         else
            mode = (roll < 78) ? MODE_REMOVE : MODE_INSERT;
         // alternate stretches with and without sender gaps
         if (calm_left > 0) begin
            calm_left--;
            gap = 0;
         end else if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(20, 60);
            gap = 0;
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
         end
         drain = ($urandom_range(0, 199) == 0);
         // no idling of any kind in the tail
         if (n >= RANDOM_ITEMS - TAIL_ITEMS) begin
            gap   = 0;
            drain = 1'b0;
         end
         add_item(mode, pick_position(mode), $urandom, $urandom_range(0, 3) != 0, gap, drain);
      end
   endtask

   // drive requests; predict each one at the edge it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.mode       <= MODE_READ;
         req_bus.position   <= '0;
         req_bus.item_value <= '0;
         req_bus.item_given <= 1'b0;
         have_item = 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_q.push_back(apply_request(cur_item));
            have_item = 1'b0;
         end
         if (!have_item && pending_q.size() > 0) begin
            cur_item  = pending_q.pop_front();
            have_item = 1'b1;
            gap_left  = cur_item.gap_before;
         end
         tail_quiet <= (pending_q.size() < TAIL_ITEMS);
         if (have_item && gap_left == 0 && (!cur_item.wait_drain || expected_q.size() == 0)) begin
            req_bus.valid      <= 1'b1;
            req_bus.mode       <= cur_item.mode;
            req_bus.position   <= cur_item.position;
            req_bus.item_value <= cur_item.item_value;
            req_bus.item_given <= cur_item.item_given;
         end else begin
            req_bus.valid <= 1'b0;
            if (have_item && gap_left > 0)
               gap_left--;
         end
      end
   end

   // check responses and stall the result side in bursts
   always @(posedge clock) begin
      store_rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_q.size() == 0) begin
               report("response with no request outstanding");
            end else begin
               want = expected_q.pop_front();
               if (rsp_bus.status !== want.status)
                  report($sformatf("status %0d, want %0d", rsp_bus.status, want.status));
               if (rsp_bus.entry_value !== want.entry_value)
                  report($sformatf("entry_value %h, want %h",
                                   rsp_bus.entry_value, want.entry_value));
               if (rsp_bus.entry_total !== want.entry_total)
                  report($sformatf("entry_total %0d, want %0d",
                                   rsp_bus.entry_total, want.entry_total));
            end
         end
         if ($urandom_range(0, 99) == 0)
            stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);
         if (stall_left > 0 && !tail_quiet) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!tail_quiet && stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      for (int i = 0; i < DEPTH; i++)
         mirror_entries[i] = '0;

      // directed: empty store, ends of the range, front, middle and end inserts
      add_item(MODE_READ,   0,   '0,           1'b0, 0, 1'b0);
      add_item(MODE_REMOVE, 0,   '0,           1'b0, 0, 1'b0);
      add_item(MODE_INSERT, 1,   32'hFFFFFFFF, 1'b1, 0, 1'b0);
      add_item(MODE_INSERT, 0,   32'hFFFFFFFF, 1'b0, 0, 1'b0);
      add_item(MODE_READ,   0,   '0,           1'b0, 0, 1'b0);
      add_item(MODE_INSERT, 1,   32'hFFFFFFFF, 1'b1, 0, 1'b0);
      add_item(MODE_INSERT, 0,   32'hA5A5A5A5, 1'b1, 0, 1'b0);
      add_item(MODE_INSERT, 1,   32'h00000001, 1'b1, 0, 1'b0);
      add_item(MODE_INSERT, 4,   32'h5A5A5A5A, 1'b1, 0, 1'b0);
      add_item(MODE_READ,   3,   '0,           1'b0, 0, 1'b0);
      add_item(MODE_READ,   5,   '0,           1'b0, 0, 1'b0);
      add_item(MODE_READ,   127, '0,           1'b0, 0, 1'b0);
      add_item(MODE_UNUSED, 0,   32'hFFFFFFFF, 1'b1, 0, 1'b0);
      add_item(MODE_INSERT, 127, 32'h12345678, 1'b1, 0, 1'b0);
      add_item(MODE_INSERT, DEPTH, 32'h12345678, 1'b1, 3, 1'b0);
      add_item(MODE_REMOVE, 1,   '0,           1'b0, 0, 1'b1);
      add_item(MODE_REMOVE, 3,   '0,           1'b0, 0, 1'b0);
      add_item(MODE_REMOVE, 127, '0,           1'b0, 0, 1'b0);
      add_item(MODE_READ,   0,   '0,           1'b0, 0, 1'b0);
      add_item(MODE_READ,   1,   '0,           1'b0, 0, 1'b0);
      add_item(MODE_READ,   2,   '0,           1'b0, 0, 1'b0);
      add_item(MODE_REMOVE, 0,   '0,           1'b0, 0, 1'b0);
      build_random();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // wait for the last transaction, then for the results to drain
      while (pending_q.size() != 0 || have_item)
         @(posedge clock);
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_q.size() != 0)
         report("responses still outstanding at the end");

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // stop a hung run
   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
